[rtl/core/msbd_pkg.sv]
// msbd_pkg: widths and default sizes for the multi-source bit deserializer.
// No dependencies.
package msbd_pkg;

    localparam int ID_W          = 22;   // sender identity
    localparam int BYTE_W        = 8;    // assembled byte
    localparam int BIT_CNT_W     = 3;    // bit position within a byte
    localparam int MAX_SOURCES_D = 64;   // default table depth
    localparam int MSG_LIMIT_D   = 1024; // default message length limit

endpackage

[rtl/core/multi_source_bit_deserializer.sv]
// multi_source_bit_deserializer: per-sender bit-to-byte assembly with a source table.
// Depends on msbd_pkg (widths, default sizes).
//
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  s_      | s_valid s_ready s_sender_id s_bit_value       | in
//  m_      | m_valid m_ready m_ack_id m_byte_done          | out
//          | m_byte_value m_message_end                    |
//
// One request at a time. The source table is scanned one entry per cycle through
// the identity memory's single read port until the sender is found or the last entry
// in use is read; a new sender then takes the next free entry (an empty table is not
// scanned), and a bit from an unknown sender is dropped when the table is full.
// Reset clears the fill count and the control state; memory contents stay undefined.
// A result waiting on m_ready holds the block in its update step.
module multi_source_bit_deserializer
    import msbd_pkg::*;
#(
    parameter int MAX_SOURCES = MAX_SOURCES_D,
    parameter int MSG_LIMIT   = MSG_LIMIT_D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ID_W-1:0]   s_sender_id,
    input  logic              s_bit_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ID_W-1:0]   m_ack_id,
    output logic              m_byte_done,
    output logic [BYTE_W-1:0] m_byte_value,
    output logic              m_message_end
);

    localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
    localparam int MSG_W  = $clog2(MSG_LIMIT);
    localparam int ST_W   = MSG_W + BIT_CNT_W + BYTE_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    typedef struct packed {
        logic [MSG_W-1:0]     bytes;
        logic [BIT_CNT_W-1:0] bits;
        logic [BYTE_W-1:0]    part;
    } entry_t;

    // memories
    logic [ID_W-1:0] id_mem [MAX_SOURCES];
    logic [ST_W-1:0] st_mem [MAX_SOURCES];

    logic [1:0]        fsm_reg, fsm_next;
    logic [CNT_W-1:0]  used_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              fresh_reg, fresh_next;
    logic [ID_W-1:0]   id_reg;
    logic              bit_reg;

    logic [ID_W-1:0]   id_rd_reg;
    logic [ST_W-1:0]   st_rd_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    logic              m_valid_reg;
    logic [ID_W-1:0]   ack_id_reg;
    logic              done_reg;
    logic [BYTE_W-1:0] value_reg;
    logic              end_reg;

    logic              accept;
    logic              match;
    logic              last;
    logic              out_free;
    logic              upd_fire;

    entry_t            cur;
    entry_t            upd;
    logic [BYTE_W-1:0] part_n;
    logic [MSG_W-1:0]  bytes_inc;
    logic              upd_done;
    logic              upd_end;

    assign s_ready  = (fsm_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign upd_fire = (fsm_reg == ST_UPDATE) && out_free;

    assign match = (id_rd_reg == id_reg);
    assign last  = (CNT_W'({1'b0, idx_reg}) + CNT_W'(1)) == used_reg;

    always_comb begin
        fsm_next   = fsm_reg;
        idx_next   = idx_reg;
        fresh_next = fresh_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        case (fsm_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    if (used_reg == '0) begin
                        fresh_next = 1'b1;
                        fsm_next   = ST_UPDATE;
                    end else begin
                        fresh_next = 1'b0;
                        rd_en      = 1'b1;
                        fsm_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    fsm_next = ST_UPDATE;
                end else if (last) begin
                    if (used_reg == CNT_W'(MAX_SOURCES)) begin
                        fsm_next = ST_IDLE;   // table full: drop
                    end else begin
                        idx_next   = IDX_W'(used_reg);
                        fresh_next = 1'b1;
                        fsm_next   = ST_UPDATE;
                    end
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd_addr  = idx_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    fsm_next = ST_IDLE;
                end
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    // read-modify-write of the entry
    always_comb begin
        cur       = fresh_reg ? entry_t'('0) : entry_t'(st_rd_reg);
        part_n    = cur.part | (BYTE_W'(bit_reg) << cur.bits);
        upd_done  = (cur.bits == BIT_CNT_W'(BYTE_W - 1));
        bytes_inc = cur.bytes + MSG_W'(1);
        upd_end   = upd_done && ((part_n == '0) || (bytes_inc >= MSG_W'(MSG_LIMIT - 1)));
        if (upd_done) begin
            upd.bytes = upd_end ? '0 : bytes_inc;
            upd.bits  = '0;
            upd.part  = '0;
        end else begin
            upd.bytes = cur.bytes;
            upd.bits  = cur.bits + BIT_CNT_W'(1);
            upd.part  = part_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            id_rd_reg <= id_mem[rd_addr];
            st_rd_reg <= st_mem[rd_addr];
        end
        if (upd_fire) begin
            st_mem[idx_reg] <= upd;
            if (fresh_reg) begin
                id_mem[idx_reg] <= id_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg <= fsm_next;
            if (upd_fire && fresh_reg) begin
                used_reg <= used_reg + CNT_W'(1);
            end
            if (upd_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        fresh_reg <= fresh_next;
        if (accept) begin
            id_reg  <= s_sender_id;
            bit_reg <= s_bit_value;
        end
        if (upd_fire) begin
            ack_id_reg <= id_reg;
            done_reg   <= upd_done;
            value_reg  <= upd_done ? part_n : '0;
            end_reg    <= upd_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ack_id      = ack_id_reg;
    assign m_byte_done   = done_reg;
    assign m_byte_value  = value_reg;
    assign m_message_end = end_reg;

endmodule
